### hw/rtl/scan_alert_mode_controller_top_defines.svh
// Assertion macros used by the core of the scan and alert mode controller.
`ifndef SCAN_ALERT_MODE_CONTROLLER_TOP_DEFINES_SVH
`define SCAN_ALERT_MODE_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SAMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SAMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/samc_pkg.sv
// Types, constants and helper functions of the scan and alert mode controller.
package samc_pkg;

  localparam int TIMER_WIDTH_DEFAULT = 20;
  localparam int PERIOD_W = 16;
  localparam int HOLD_W   = 20;
  localparam int SIM_W    = 10;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [SIM_W-1:0]    SIM_MAX   = 10'd1000;
  localparam logic [PERIOD_W-1:0] CNT16_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SCAN    = 3'd1,
    MODE_MATCH   = 3'd2,
    MODE_NOMATCH = 3'd3,
    MODE_PANIC   = 3'd4,
    MODE_NETERR  = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    FUNC_TICK       = 3'd0,
    FUNC_REQUEST    = 3'd1,
    FUNC_PANIC      = 3'd2,
    FUNC_MATCH      = 3'd3,
    FUNC_NOMATCH    = 3'd4,
    FUNC_CAM_ERROR  = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    MSG_NONE      = 3'd0,
    MSG_SCAN      = 3'd1,
    MSG_MATCH     = 3'd2,
    MSG_NOMATCH   = 3'd3,
    MSG_PANIC     = 3'd4,
    MSG_NETERR    = 3'd5,
    MSG_HEARTBEAT = 3'd6
  } msg_t;

  typedef enum logic [2:0] {
    REG_HEARTBEAT_PERIOD = 3'd0,
    REG_SCAN_TIMEOUT     = 3'd1,
    REG_MATCH_HOLD       = 3'd2,
    REG_NOMATCH_HOLD     = 3'd3,
    REG_PANIC_HOLD       = 3'd4,
    REG_NETERR_HOLD      = 3'd5,
    REG_BLINK_PERIOD     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] heartbeat_period;
    logic [HOLD_W-1:0]   scan_timeout;
    logic [HOLD_W-1:0]   match_hold;
    logic [HOLD_W-1:0]   nomatch_hold;
    logic [HOLD_W-1:0]   panic_hold;
    logic [HOLD_W-1:0]   neterr_hold;
    logic [PERIOD_W-1:0] blink_period;
  } cfg_t;

  typedef struct packed {
    logic buzzer;
    logic red;
    logic amber;
    logic green;
  } drive_t;

  localparam cfg_t CFG_RESET = '{
    heartbeat_period: 16'd5000,
    scan_timeout:     20'd10000,
    match_hold:       20'd5000,
    nomatch_hold:     20'd3000,
    panic_hold:       20'd10000,
    neterr_hold:      20'd5000,
    blink_period:     16'd250
  };

  localparam drive_t DRIVE_RESET = '{buzzer: 1'b0, red: 1'b0, amber: 1'b0, green: 1'b1};

  function automatic drive_t entry_drive(mode_t m);
    drive_t d;
    d = '0;
    case (m)
      MODE_IDLE:    d.green = 1'b1;
      MODE_SCAN:    d.amber = 1'b1;
      MODE_MATCH:   begin
        d.red    = 1'b1;
        d.buzzer = 1'b1;
      end
      MODE_NOMATCH: d.green = 1'b1;
      MODE_PANIC:   begin
        d.red    = 1'b1;
        d.buzzer = 1'b1;
      end
      default:      d.amber = 1'b1;
    endcase
    return d;
  endfunction

  function automatic msg_t entry_msg(mode_t m);
    msg_t r;
    case (m)
      MODE_IDLE:    r = MSG_NONE;
      MODE_SCAN:    r = MSG_SCAN;
      MODE_MATCH:   r = MSG_MATCH;
      MODE_NOMATCH: r = MSG_NOMATCH;
      MODE_PANIC:   r = MSG_PANIC;
      default:      r = MSG_NETERR;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/samc_regs.sv
// APB configuration registers of the scan and alert mode controller.
module samc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [samc_pkg::ADDR_W-1:0]   paddr,
  input  logic [samc_pkg::DATA_W-1:0]   pwdata,
  output logic [samc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output samc_pkg::cfg_t                cfg
);

  samc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = samc_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= samc_pkg::CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        samc_pkg::REG_HEARTBEAT_PERIOD: cfg.heartbeat_period <= pwdata[15:0];
        samc_pkg::REG_SCAN_TIMEOUT:     cfg.scan_timeout     <= pwdata[19:0];
        samc_pkg::REG_MATCH_HOLD:       cfg.match_hold       <= pwdata[19:0];
        samc_pkg::REG_NOMATCH_HOLD:     cfg.nomatch_hold     <= pwdata[19:0];
        samc_pkg::REG_PANIC_HOLD:       cfg.panic_hold       <= pwdata[19:0];
        samc_pkg::REG_NETERR_HOLD:      cfg.neterr_hold      <= pwdata[19:0];
        samc_pkg::REG_BLINK_PERIOD:     cfg.blink_period     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      samc_pkg::REG_HEARTBEAT_PERIOD: prdata = {16'd0, cfg.heartbeat_period};
      samc_pkg::REG_SCAN_TIMEOUT:     prdata = {12'd0, cfg.scan_timeout};
      samc_pkg::REG_MATCH_HOLD:       prdata = {12'd0, cfg.match_hold};
      samc_pkg::REG_NOMATCH_HOLD:     prdata = {12'd0, cfg.nomatch_hold};
      samc_pkg::REG_PANIC_HOLD:       prdata = {12'd0, cfg.panic_hold};
      samc_pkg::REG_NETERR_HOLD:      prdata = {12'd0, cfg.neterr_hold};
      samc_pkg::REG_BLINK_PERIOD:     prdata = {16'd0, cfg.blink_period};
      default:                        prdata = '0;
    endcase
  end

endmodule

### hw/rtl/samc_core.sv
// Mode state machine, timers and result register of the scan and alert controller.
`include "scan_alert_mode_controller_top_defines.svh"

module samc_core #(
  parameter int TIMER_WIDTH = samc_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  samc_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    func,
  input  logic [samc_pkg::SIM_W-1:0]    similarity,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    mode,
  output logic                          lamp_green,
  output logic                          lamp_amber,
  output logic                          lamp_red,
  output logic                          buzzer_on,
  output logic                          capture_request,
  output logic [2:0]                    message_code,
  output logic [samc_pkg::SIM_W-1:0]    reported_similarity
);

  localparam int CMP_W = (TIMER_WIDTH > samc_pkg::HOLD_W) ? TIMER_WIDTH : samc_pkg::HOLD_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  // State
  samc_pkg::mode_t                  cur_mode, cur_mode_next;
  logic [TIMER_WIDTH-1:0]           time_in_mode, time_in_mode_next;
  logic [samc_pkg::PERIOD_W-1:0]    hb_count, hb_count_next;
  logic [samc_pkg::PERIOD_W-1:0]    toggle_count, toggle_count_next;
  logic                             amber_phase, amber_phase_next;
  logic [samc_pkg::SIM_W-1:0]       held_sim, held_sim_next;
  samc_pkg::drive_t                 drive, drive_next;

  samc_pkg::msg_t                   msg;
  logic                             capture;
  logic                             in_accept;
  logic                             enter;
  samc_pkg::mode_t                  target;
  logic [samc_pkg::HOLD_W-1:0]      hold;
  logic                             has_hold;
  logic [TIMER_WIDTH-1:0]           tim_inc;
  logic [samc_pkg::PERIOD_W-1:0]    hb_inc;
  logic [samc_pkg::PERIOD_W-1:0]    tog_inc;
  samc_pkg::func_t                  fn;

  // The result register frees the input side whenever it is empty or drains.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign fn        = samc_pkg::func_t'(func);

  assign tim_inc = (time_in_mode == TIMER_MAX) ? time_in_mode : time_in_mode + 1'b1;
  assign hb_inc  = (hb_count == samc_pkg::CNT16_MAX) ? hb_count : hb_count + 1'b1;
  assign tog_inc = (toggle_count == samc_pkg::CNT16_MAX) ? toggle_count : toggle_count + 1'b1;

  always_comb begin
    cur_mode_next     = cur_mode;
    time_in_mode_next = time_in_mode;
    hb_count_next     = hb_count;
    toggle_count_next = toggle_count;
    amber_phase_next  = amber_phase;
    held_sim_next     = held_sim;
    drive_next        = drive;
    msg               = samc_pkg::MSG_NONE;
    capture           = 1'b0;
    enter             = 1'b0;
    target            = samc_pkg::MODE_IDLE;
    hold              = '0;
    has_hold          = 1'b1;

    case (fn)
      samc_pkg::FUNC_TICK: begin
        time_in_mode_next = tim_inc;
        hb_count_next     = hb_inc;
        toggle_count_next = tog_inc;
        case (cur_mode)
          samc_pkg::MODE_IDLE: begin
            has_hold = 1'b0;
            if (hb_inc >= cfg.heartbeat_period) begin
              msg           = samc_pkg::MSG_HEARTBEAT;
              hb_count_next = '0;
            end
          end
          samc_pkg::MODE_SCAN:    hold = cfg.scan_timeout;
          samc_pkg::MODE_MATCH:   hold = cfg.match_hold;
          samc_pkg::MODE_NOMATCH: hold = cfg.nomatch_hold;
          samc_pkg::MODE_PANIC:   hold = cfg.panic_hold;
          default: begin
            // Blink amber while the network error persists.
            if (tog_inc >= cfg.blink_period) begin
              amber_phase_next  = !amber_phase;
              drive_next.amber  = !amber_phase;
              toggle_count_next = '0;
            end
            hold = cfg.neterr_hold;
          end
        endcase
        if (has_hold && (CMP_W'(tim_inc) >= CMP_W'(hold))) begin
          enter  = 1'b1;
          target = (cur_mode == samc_pkg::MODE_SCAN) ? samc_pkg::MODE_NETERR
                                                     : samc_pkg::MODE_IDLE;
        end
      end
      samc_pkg::FUNC_PANIC: begin
        enter  = 1'b1;
        target = samc_pkg::MODE_PANIC;
      end
      samc_pkg::FUNC_REQUEST: begin
        // Ignore a request while a scan is already running.
        if (cur_mode != samc_pkg::MODE_SCAN) begin
          enter   = 1'b1;
          target  = samc_pkg::MODE_SCAN;
          capture = 1'b1;
        end
      end
      samc_pkg::FUNC_MATCH: begin
        if (cur_mode == samc_pkg::MODE_SCAN) begin
          held_sim_next = (similarity > samc_pkg::SIM_MAX) ? samc_pkg::SIM_MAX
                                                           : similarity;
          enter  = 1'b1;
          target = samc_pkg::MODE_MATCH;
        end
      end
      samc_pkg::FUNC_NOMATCH: begin
        if (cur_mode == samc_pkg::MODE_SCAN) begin
          enter  = 1'b1;
          target = samc_pkg::MODE_NOMATCH;
        end
      end
      samc_pkg::FUNC_CAM_ERROR: begin
        if (cur_mode == samc_pkg::MODE_SCAN) begin
          enter  = 1'b1;
          target = samc_pkg::MODE_NETERR;
        end
      end
      default: ;
    endcase

    if (enter) begin
      cur_mode_next     = target;
      time_in_mode_next = '0;
      toggle_count_next = '0;
      amber_phase_next  = (target == samc_pkg::MODE_NETERR);
      drive_next        = samc_pkg::entry_drive(target);
      msg               = samc_pkg::entry_msg(target);
      if (target == samc_pkg::MODE_IDLE) begin
        hb_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode     <= samc_pkg::MODE_IDLE;
      time_in_mode <= '0;
      hb_count     <= '0;
      toggle_count <= '0;
      amber_phase  <= 1'b0;
      held_sim     <= '0;
      drive        <= samc_pkg::DRIVE_RESET;
    end else if (in_accept) begin
      cur_mode     <= cur_mode_next;
      time_in_mode <= time_in_mode_next;
      hb_count     <= hb_count_next;
      toggle_count <= toggle_count_next;
      amber_phase  <= amber_phase_next;
      held_sim     <= held_sim_next;
      drive        <= drive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode                <= cur_mode_next;
      lamp_green          <= drive_next.green;
      lamp_amber          <= drive_next.amber;
      lamp_red            <= drive_next.red;
      buzzer_on           <= drive_next.buzzer;
      capture_request     <= capture;
      message_code        <= msg;
      reported_similarity <= held_sim_next;
    end
  end

  `SAMC_ASSERT_NOW(a_capture_enters_scan,
    out_valid && capture_request,
    mode == samc_pkg::MODE_SCAN && message_code == samc_pkg::MSG_SCAN,
    "capture request without entering scanning")
  `SAMC_ASSERT_NOW(a_heartbeat_only_idle,
    out_valid && message_code == samc_pkg::MSG_HEARTBEAT,
    mode == samc_pkg::MODE_IDLE,
    "heartbeat sent outside idle")
  `SAMC_ASSERT_NEXT(a_panic_always_enters,
    in_accept && fn == samc_pkg::FUNC_PANIC,
    cur_mode == samc_pkg::MODE_PANIC && time_in_mode == '0,
    "panic press did not enter panic")
  `SAMC_ASSERT_NOW(a_alarm_drive,
    cur_mode == samc_pkg::MODE_MATCH || cur_mode == samc_pkg::MODE_PANIC,
    drive.red && drive.buzzer && !drive.green,
    "alarm state without red lamp and buzzer")
  `SAMC_ASSERT_NOW(a_similarity_range,
    1'b1,
    held_sim <= samc_pkg::SIM_MAX,
    "held similarity above full scale")

endmodule

### hw/rtl/scan_alert_mode_controller_top.sv
// Top level of the scan and alert mode controller.
// Takes one item (a millisecond tick or one event) per clock while ready; gives one
// result per item, in the cycle after acceptance. The mode update and all timer
// compares sit between the state registers and a result register; the input
// stays ready while that register is empty or being taken, so full rate is one
// item per cycle when the sink keeps up. Timer registers are written through the
// APB port at byte address 4*index and read back there; write them while idle.
module scan_alert_mode_controller_top #(
  parameter int TIMER_WIDTH = samc_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [samc_pkg::ADDR_W-1:0]   paddr,
  input  logic [samc_pkg::DATA_W-1:0]   pwdata,
  output logic [samc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    func,
  input  logic [samc_pkg::SIM_W-1:0]    similarity,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    mode,
  output logic                          lamp_green,
  output logic                          lamp_amber,
  output logic                          lamp_red,
  output logic                          buzzer_on,
  output logic                          capture_request,
  output logic [2:0]                    message_code,
  output logic [samc_pkg::SIM_W-1:0]    reported_similarity
);

  samc_pkg::cfg_t cfg;

  samc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  samc_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .func                (func),
    .similarity          (similarity),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .mode                (mode),
    .lamp_green          (lamp_green),
    .lamp_amber          (lamp_amber),
    .lamp_red            (lamp_red),
    .buzzer_on           (buzzer_on),
    .capture_request     (capture_request),
    .message_code        (message_code),
    .reported_similarity (reported_similarity)
  );

endmodule
